>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam int POS_W  = 11;
  localparam int CODE_W = 16;

  localparam logic [CODE_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]        DEFAULT_ATTR = 8'h07;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic              command;
    logic [CODE_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CODE_W-1:0] read_data;
    logic              scrolled;
  } tcw_out_t;

endpackage

>>> rtl/tcw_cell_ram.sv
`timescale 1ns / 1ps

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CODE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CODE_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tcw_alu.sv
`timescale 1ns / 1ps

module tcw_alu #(
  parameter int W = 11
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge
);

  always_comb begin
    res = sub ? (a - b) : (a + b);
    ge  = (a >= b);
  end

endmodule

>>> rtl/text_console_char_writer_unit.sv
`timescale 1ns / 1ps
// Newline and carriage return find the column by repeated subtraction in the shared ALU;
//   a plain character is written, the cursor advanced, then checked for a scroll.
// A scroll copies one cell per cycle through the RAM port.
// Throughput: one item at a time; result sits in an output register, next item taken.
// Reset: synchronous; a clearing pass writes ROWS*COLS blanks with in_stall high;
//   cfg writes are taken during it.

module text_console_char_writer_unit #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tcw_pkg::tcw_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tcw_pkg::tcw_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tcw_pkg::POS_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int KEEP  = CELLS - COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int XW    = (PW > POS_W) ? PW : POS_W;

  typedef enum logic [12:0] {
    S_CLR   = 13'h0001,
    S_IDLE  = 13'h0002,
    S_BS    = 13'h0004,
    S_MOD   = 13'h0008,
    S_BASE  = 13'h0010,
    S_NLADD = 13'h0020,
    S_ADV   = 13'h0040,
    S_CHK   = 13'h0080,
    S_SCP   = 13'h0100,
    S_SCR   = 13'h0200,
    S_SCFIX = 13'h0400,
    S_RD    = 13'h0800,
    S_RES   = 13'h1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     cursor_r, cursor_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] rd_r, rd_nxt;
  logic              scr_r, scr_nxt;
  logic              rng_r, rng_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CODE_W-1:0] ram_wdata, ram_rdata;

  logic [PW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_sub, alu_ge;

  logic [CODE_W-1:0] put_code;

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_alu #(
    .W (PW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign put_code = (in_data.char_code[15:8] == 8'h00) ?
                    {DEFAULT_ATTR, in_data.char_code[7:0]} : in_data.char_code;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    code_nxt      = code_r;
    rd_nxt        = rd_r;
    scr_nxt       = scr_r;
    rng_nxt       = rng_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = cursor_r[AW-1:0];
    ram_wdata = put_code;
    ram_re    = 1'b0;
    ram_raddr = AW'(in_data.cell_index);

    alu_a   = cursor_r;
    alu_b   = '0;
    alu_sub = 1'b0;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = BLANK_CELL;
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          rd_nxt   = '0;
          scr_nxt  = 1'b0;
          code_nxt = put_code;
          if (in_data.command == CMD_READ) begin
            rng_nxt   = (XW'(in_data.cell_index) < XW'(CELLS));
            ram_re    = 1'b1;
            state_nxt = S_RD;
          end else begin
            case (put_code[7:0])
              CH_BS: begin
                state_nxt = (cursor_r != '0) ? S_BS : S_RES;
              end
              CH_NL, CH_CR: begin
                rem_nxt   = cursor_r;
                state_nxt = S_MOD;
              end
              default: begin
                ram_we    = 1'b1;
                state_nxt = S_ADV;
              end
            endcase
          end
        end
      end
      S_BS: begin
        alu_b      = PW'(1);
        alu_sub    = 1'b1;
        cursor_nxt = alu_res;
        ram_we     = 1'b1;
        ram_waddr  = alu_res[AW-1:0];
        ram_wdata  = {code_r[15:8], CH_SPACE};
        state_nxt  = S_RES;
      end
      S_MOD: begin
        alu_a   = rem_r;
        alu_b   = PW'(COLS);
        alu_sub = 1'b1;
        if (alu_ge) begin
          rem_nxt = alu_res;
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        alu_b      = rem_r;
        alu_sub    = 1'b1;
        cursor_nxt = alu_res;
        state_nxt  = (code_r[7:0] == CH_NL) ? S_NLADD : S_RES;
      end
      S_NLADD: begin
        alu_b      = PW'(COLS);
        cursor_nxt = alu_res;
        state_nxt  = S_CHK;
      end
      S_ADV: begin
        alu_b      = PW'(1);
        cursor_nxt = alu_res;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        alu_b     = PW'(CELLS);
        alu_sub   = 1'b1;
        state_nxt = alu_ge ? S_SCP : S_RES;
      end
      S_SCP: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(COLS);
        cnt_nxt   = '0;
        scr_nxt   = 1'b1;
        state_nxt = S_SCR;
      end
      S_SCR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = (cnt_r < AW'(KEEP)) ? ram_rdata : BLANK_CELL;
        ram_re    = (cnt_r < AW'(KEEP - 1));
        ram_raddr = cnt_r + AW'(COLS + 1);
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SCFIX;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_SCFIX: begin
        alu_b      = PW'(COLS);
        alu_sub    = 1'b1;
        cursor_nxt = alu_res;
        state_nxt  = S_RES;
      end
      S_RD: begin
        rd_nxt    = rng_r ? ram_rdata : '0;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cursor_pos = POS_W'(cursor_r);
          out_data_nxt.read_data  = rd_r;
          out_data_nxt.scrolled   = scr_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      if (XW'(cfg_data) >= XW'(CELLS)) begin
        cursor_nxt = PW'(CELLS - 1);
      end else begin
        cursor_nxt = PW'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cursor_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    code_r     <= code_nxt;
    rd_r       <= rd_nxt;
    scr_r      <= scr_nxt;
    rng_r      <= rng_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input tcw_pkg::tcw_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input tcw_pkg::tcw_out_t         out_data
);
  import tcw_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset starts the clearing pass with nothing offered
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not busy after reset");

  // the block is busy in the cycle after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // a read never reports a scroll, a put never returns cell data
  a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_data != '0) |-> !out_data.scrolled)
    else $error("scroll flagged together with read data");

endmodule

bind text_console_char_writer_unit tcw_checker u_tcw_checker (.*);
